// ===== sv/bcgd_pkg.sv =====
// Package for the button click gesture detector: types, codes and reset values.
`timescale 1ns / 1ps
`default_nettype none

package bcgd_pkg;

  // Default number of buttons tracked
  localparam int unsigned NumButtonsDefault = 8;

  // Register reset values
  localparam logic [15:0] DebounceRst    = 16'd50;
  localparam logic [15:0] LongClickRst   = 16'd1000;
  localparam logic [15:0] DoubleClickRst = 16'd300;
  localparam logic [15:0] HoldRepeatRst  = 16'd200;
  localparam logic [7:0]  IdleMaskRst    = 8'hFF;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_DEBOUNCE     = 3'd0,
    REG_LONG_CLICK   = 3'd1,
    REG_DOUBLE_CLICK = 3'd2,
    REG_HOLD_REPEAT  = 3'd3,
    REG_IDLE_MASK    = 3'd4
  } cfg_reg_e;

  // Per-button gesture phase, one-hot
  typedef enum logic [5:0] {
    PH_FREE      = 6'b000001,
    PH_DEBOUNCE  = 6'b000010,
    PH_PRESSED   = 6'b000100,
    PH_RELEASED  = 6'b001000,
    PH_LONG_HOLD = 6'b010000,
    PH_DOUBLE    = 6'b100000
  } phase_e;

  // Event codes on the result channel
  typedef enum logic [2:0] {
    EV_PRESSED = 3'd0,
    EV_CLICKED = 3'd1,
    EV_DOUBLE  = 3'd2,
    EV_LONG    = 3'd3,
    EV_HOLD    = 3'd4
  } event_e;

  // One entry of the button state memory
  typedef struct packed {
    phase_e      phase;
    logic [31:0] stamp;
  } entry_t;

endpackage

`default_nettype wire

// ===== sv/button_click_gesture_detector.sv =====
// Button click gesture detector: per-button debounce, click, double click, long press, hold.
// Path: an accepted poll is registered in stage 1, and its event then in the output register on out_valid_o.
// Throughput: one poll per cycle while out_stall_i does not hold a result; set by the read-modify-write of the
//   button state memory, kept at full rate by a bypass of the write-back into the next read of the same button.
// A stalled result stalls the input side only while stage 1 also holds a poll (stage 1 as buffer).
// Reset: registers return to their defaults and every button reads as free through
//   per-entry valid flags; no clearing pass, polls are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none

module button_click_gesture_detector #(
  parameter int unsigned NUM_BUTTONS = bcgd_pkg::NumButtonsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  // poll request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  button_index_i,
  input  wire logic        pin_level_i,
  input  wire logic [31:0] now_ms_i,
  // event request channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       event_button_o,
  output logic [2:0]       event_kind_o
);

  import bcgd_pkg::*;

  localparam int unsigned AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  // Configuration registers
  logic [15:0] debounce_q, long_click_q, double_click_q, hold_repeat_q;
  logic [7:0]  idle_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q     <= DebounceRst;
      long_click_q   <= LongClickRst;
      double_click_q <= DoubleClickRst;
      hold_repeat_q  <= HoldRepeatRst;
      idle_mask_q    <= IdleMaskRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DEBOUNCE:     debounce_q     <= cfg_wdata_i;
        REG_LONG_CLICK:   long_click_q   <= cfg_wdata_i;
        REG_DOUBLE_CLICK: double_click_q <= cfg_wdata_i;
        REG_HOLD_REPEAT:  hold_repeat_q  <= cfg_wdata_i;
        REG_IDLE_MASK:    idle_mask_q    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshake and stage control
  logic in_acc, s1_adv, s1_vld_q;
  logic [AW-1:0] in_addr;

  assign s1_adv     = !out_valid_o || !out_stall_i;
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_addr    = AW'(button_index_i);

  // Stage 1 request registers
  logic [2:0]    s1_btn_q;
  logic [AW-1:0] s1_addr_q;
  logic          s1_lvl_q, s1_ok_q;
  logic [31:0]   s1_now_q;

  // stage 1 loads whenever it is empty or moving on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_btn_q  <= button_index_i;
      s1_addr_q <= in_addr;
      s1_lvl_q  <= pin_level_i;
      s1_now_q  <= now_ms_i;
      s1_ok_q   <= (32'(button_index_i) < NUM_BUTTONS);
    end
  end

  // State memory, valid flags and write-back bypass
  entry_t               mem_q [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] ent_vld_q;
  entry_t               rd_q;
  logic                 rd_vld_q;
  logic                 wr_en;
  entry_t               wr_data;
  logic                 byp_vld_q;
  logic [AW-1:0]        byp_addr_q;
  entry_t               byp_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[s1_addr_q] <= wr_data;
    end
    if (in_acc) begin
      rd_q <= mem_q[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      byp_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld_q[s1_addr_q] <= 1'b1;
      end
      if (in_acc) begin
        rd_vld_q <= ent_vld_q[in_addr];
      end
      // bypass covers a write landing on the same edge as the next read
      if (s1_adv) begin
        byp_vld_q <= wr_en;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && wr_en) begin
      byp_addr_q <= s1_addr_q;
      byp_data_q <= wr_data;
    end
  end

  // Current entry: bypass first, then memory, invalid entries read as free
  entry_t cur;
  logic   pressed;
  logic [31:0] elapsed;
  logic   ev_vld;
  event_e ev;

  always_comb begin
    if (byp_vld_q && (byp_addr_q == s1_addr_q)) begin
      cur = byp_data_q;
    end else if (rd_vld_q) begin
      cur = rd_q;
    end else begin
      cur = '{phase: PH_FREE, stamp: 32'd0};
    end
  end

  assign pressed = (s1_lvl_q != idle_mask_q[s1_btn_q]);
  assign elapsed = s1_now_q - cur.stamp;
  assign wr_en   = s1_vld_q && s1_ok_q && s1_adv;

  // Phase update
  always_comb begin
    wr_data = cur;
    ev_vld  = 1'b0;
    ev      = EV_PRESSED;
    case (cur.phase)
      PH_DEBOUNCE: begin
        if (pressed) begin
          if (elapsed > 32'(debounce_q)) begin
            wr_data = '{phase: PH_PRESSED, stamp: s1_now_q};
            ev_vld  = 1'b1;
            ev      = EV_PRESSED;
          end
        end else begin
          wr_data = '{phase: PH_FREE, stamp: 32'd0};
        end
      end
      PH_PRESSED: begin
        if (pressed) begin
          if (elapsed > 32'(long_click_q)) begin
            wr_data = '{phase: PH_LONG_HOLD, stamp: s1_now_q};
            ev_vld  = 1'b1;
            ev      = EV_LONG;
          end
        end else if (elapsed > 32'(debounce_q)) begin
          wr_data = '{phase: PH_RELEASED, stamp: s1_now_q};
        end
      end
      PH_RELEASED: begin
        if (pressed) begin
          // second press only inside the double click window
          if (elapsed > 32'(debounce_q) && elapsed < 32'(double_click_q)) begin
            wr_data = '{phase: PH_DOUBLE, stamp: s1_now_q};
          end
        end else if (elapsed > 32'(double_click_q)) begin
          wr_data = '{phase: PH_FREE, stamp: 32'd0};
          ev_vld  = 1'b1;
          ev      = EV_CLICKED;
        end
      end
      PH_LONG_HOLD: begin
        if (pressed) begin
          if (elapsed > 32'(hold_repeat_q)) begin
            wr_data.stamp = s1_now_q;
            ev_vld        = 1'b1;
            ev            = EV_HOLD;
          end
        end else if (elapsed > 32'(debounce_q)) begin
          wr_data = '{phase: PH_FREE, stamp: 32'd0};
        end
      end
      PH_DOUBLE: begin
        if (!pressed && elapsed > 32'(debounce_q)) begin
          wr_data = '{phase: PH_FREE, stamp: 32'd0};
          ev_vld  = 1'b1;
          ev      = EV_DOUBLE;
        end
      end
      default: begin
        // free and any unknown code
        if (pressed) begin
          wr_data = '{phase: PH_DEBOUNCE, stamp: s1_now_q};
        end else begin
          wr_data = '{phase: PH_FREE, stamp: 32'd0};
        end
      end
    endcase
  end

  // Output register
  logic out_vld_q;
  logic [2:0] out_btn_q, out_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= s1_vld_q && s1_ok_q && ev_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_vld_q) begin
      out_btn_q  <= s1_btn_q;
      out_kind_q <= ev;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign event_button_o = out_btn_q;
  assign event_kind_o   = out_kind_q;

endmodule

`default_nettype wire
